@@ hdl/lfo_flanger_defines.svh @@
// ----------------------------------------------------------------------------
// lfo_flanger_defines.svh
// Assertion macros used by the flanger checker.
// ----------------------------------------------------------------------------
`ifndef LFO_FLANGER_DEFINES_SVH
`define LFO_FLANGER_DEFINES_SVH

// Concurrent check that is switched off while reset is high.
`define LFOFL_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Concurrent check that also holds across reset.
`define LFOFL_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ hdl/lfofl_pkg.sv @@
// ----------------------------------------------------------------------------
// lfofl_pkg
// Shared widths, defaults, datapath command codes and sine polynomial
// coefficients for the flanger block.
// ----------------------------------------------------------------------------
package lfofl_pkg;

   // Default storage sizes.
   localparam int DELAY_DEPTH_DEF     = 512;
   localparam int SINE_TABLE_BITS_DEF = 10;

   // Field and register widths.
   localparam int SAMPLE_W   = 16;
   localparam int DEPTH_W    = 13;
   localparam int PERIOD_W   = 21;
   localparam int CENTER_W   = 9;
   localparam int AMP_W      = 8;
   localparam int CSR_DATA_W = 21;
   localparam int CSR_INDEX_W = 3;

   // Sine polynomial, Q16.
   localparam int  MAG_W       = 17;
   localparam int  POLY_STEPS  = 4;
   localparam logic [MAG_W-1:0] SINE_ONE  = 17'd65536;
   localparam logic [MAG_W-1:0] POLY_SEED = 17'd11;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_TAKE,
      OP_STORE,
      OP_DIV,
      OP_XPOS,
      OP_SQ,
      OP_X2,
      OP_PMUL,
      OP_PSUB,
      OP_XMUL,
      OP_MAG,
      OP_AMP,
      OP_DELAY,
      OP_ADDR,
      OP_RDP,
      OP_RDN,
      OP_INTA,
      OP_INTB,
      OP_MIX,
      OP_SAT,
      OP_PASS
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic enable;
      logic wpos_last;
   } dp_status_type;

   // Horner coefficients, applied from the innermost term outward.
   function automatic logic [MAG_W-1:0] poly_coef(input logic [1:0] idx);
      logic [MAG_W-1:0] coef;
      case (idx)
         2'd0:    coef = 17'd307;
         2'd1:    coef = 17'd5223;
         2'd2:    coef = 17'd42334;
         default: coef = 17'd102944;
      endcase
      return coef;
   endfunction

endpackage

@@ hdl/lfo_flanger.sv @@
// Flanger sequence: each accepted item is stored, then run through the
// bit-serial phase divider and the shared multiplier's sequence before its
// result is loaded; no new item is taken until then, and a stalled output
// holds the load. With the effect disabled, the sample is passed straight on.
// After synchronous reset the delay memory is cleared one entry a cycle, all
// of its entries, while req_stall is held high.
// ----------------------------------------------------------------------------
// lfo_flanger
// Flanger with a sine LFO and a linearly interpolated delay line, built as a
// sequencer and a datapath.
// ----------------------------------------------------------------------------
module lfo_flanger #(
   parameter int DELAY_DEPTH     = lfofl_pkg::DELAY_DEPTH_DEF,
   parameter int SINE_TABLE_BITS = lfofl_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [lfofl_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [lfofl_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                  csr_wr_en,
   input  logic [lfofl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lfofl_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import lfofl_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer.
   lfofl_ctrl #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath.
   lfofl_dp #(
      .DELAY_DEPTH     (DELAY_DEPTH),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_sample_in  (req_sample_in),
      .rsp_sample_out (rsp_sample_out),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

@@ hdl/lfofl_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfofl_ctrl
// Sequencer for the flanger: clears the delay memory after reset, then
// steps the datapath through one sample at a time and owns the result valid.
// ----------------------------------------------------------------------------
module lfofl_ctrl #(
   parameter int SINE_TABLE_BITS = lfofl_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output lfofl_pkg::dp_cmd_type   cmd,
   input  lfofl_pkg::dp_status_type status
);
   import lfofl_pkg::*;

   localparam int CW = $clog2(SINE_TABLE_BITS);

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_STORE,
      S_DIV,
      S_XPOS,
      S_SQ,
      S_X2,
      S_PMUL,
      S_PSUB,
      S_XMUL,
      S_MAG,
      S_AMP,
      S_DELAY,
      S_ADDR,
      S_RDP,
      S_RDN,
      S_INTA,
      S_INTB,
      S_MIX,
      S_SAT,
      S_PASS
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;
   logic            load_out;

   // The output register can take a result when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state, step counter and datapath command.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_NONE;
      cmd.idx  = cnt_ff[1:0];
      load_out = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.wpos_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_TAKE;
               state_in = status.enable ? S_STORE : S_PASS;
            end
         end
         S_STORE: begin
            cmd.op   = OP_STORE;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (cnt_ff == CW'(SINE_TABLE_BITS - 1)) begin
               cnt_in   = '0;
               state_in = S_XPOS;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_XPOS: begin
            cmd.op   = OP_XPOS;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op   = OP_SQ;
            state_in = S_X2;
         end
         S_X2: begin
            cmd.op   = OP_X2;
            state_in = S_PMUL;
         end
         S_PMUL: begin
            cmd.op   = OP_PMUL;
            state_in = S_PSUB;
         end
         S_PSUB: begin
            cmd.op = OP_PSUB;
            if (cnt_ff == CW'(POLY_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_XMUL;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_PMUL;
            end
         end
         S_XMUL: begin
            cmd.op   = OP_XMUL;
            state_in = S_MAG;
         end
         S_MAG: begin
            cmd.op   = OP_MAG;
            state_in = S_AMP;
         end
         S_AMP: begin
            cmd.op   = OP_AMP;
            state_in = S_DELAY;
         end
         S_DELAY: begin
            cmd.op   = OP_DELAY;
            state_in = S_ADDR;
         end
         S_ADDR: begin
            cmd.op   = OP_ADDR;
            state_in = S_RDP;
         end
         S_RDP: begin
            cmd.op   = OP_RDP;
            state_in = S_RDN;
         end
         S_RDN: begin
            cmd.op   = OP_RDN;
            state_in = S_INTA;
         end
         S_INTA: begin
            cmd.op   = OP_INTA;
            state_in = S_INTB;
         end
         S_INTB: begin
            cmd.op   = OP_INTB;
            state_in = S_MIX;
         end
         S_MIX: begin
            cmd.op   = OP_MIX;
            state_in = S_SAT;
         end
         S_SAT: begin
            if (out_free) begin
               cmd.op   = OP_SAT;
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_PASS: begin
            if (out_free) begin
               cmd.op   = OP_PASS;
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The result stays valid until taken unless a new one replaces it.
   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/lfofl_dp.sv @@
// ----------------------------------------------------------------------------
// lfofl_dp
// Flanger datapath: configuration registers, delay memory, LFO time counter,
// serial phase divider, shared 18x18 multiplier and the output register.
// ----------------------------------------------------------------------------
module lfofl_dp #(
   parameter int DELAY_DEPTH     = lfofl_pkg::DELAY_DEPTH_DEF,
   parameter int SINE_TABLE_BITS = lfofl_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_wr_en,
   input  logic [lfofl_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [lfofl_pkg::CSR_DATA_W-1:0]            csr_wr_data,
   input  logic signed [lfofl_pkg::SAMPLE_W-1:0]       req_sample_in,
   output logic signed [lfofl_pkg::SAMPLE_W-1:0]       rsp_sample_out,
   input  lfofl_pkg::dp_cmd_type                       cmd,
   output lfofl_pkg::dp_status_type                    status
);
   import lfofl_pkg::*;

   localparam int AW  = $clog2(DELAY_DEPTH);
   localparam int QB  = SINE_TABLE_BITS - 2;
   localparam int DLW = ((AW + 9) > 19) ? (AW + 9) : 19;
   localparam logic [AW:0]            DEPTH_X = (AW + 1)'(DELAY_DEPTH);
   localparam logic signed [DLW-1:0]  DLY_MIN = DLW'(256);
   localparam logic signed [DLW-1:0]  DLY_MAX = DLW'(DELAY_DEPTH * 256 - 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMP    = 3'd4;

   // Configuration.
   logic                  enable_ff;
   logic [DEPTH_W-1:0]    depth_ff;
   logic [PERIOD_W-1:0]   period_ff;
   logic [CENTER_W-1:0]   center_ff;
   logic [AMP_W-1:0]      amp_ff;

   // Sample state.
   logic signed [SAMPLE_W-1:0] delay_mem [DELAY_DEPTH];
   logic [AW-1:0]              wpos_ff;
   logic [PERIOD_W-1:0]        lfo_time_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;

   // Working registers.
   logic [PERIOD_W-1:0]         rem_ff;
   logic [SINE_TABLE_BITS-1:0]  quo_ff;
   logic                        neg_ff;
   logic [MAG_W-1:0]            x_ff;
   logic [MAG_W-1:0]            x2_ff;
   logic [MAG_W-1:0]            p_ff;
   logic signed [35:0]          prod_ff;
   logic [AW-1:0]               n_ff;
   logic [7:0]                  f_ff;
   logic [AW-1:0]               ip_ff;
   logic [AW-1:0]               inx_ff;
   logic signed [SAMPLE_W-1:0]  rd_ff;
   logic signed [24:0]          acc_ff;
   logic signed [SAMPLE_W-1:0]  delayed_ff;
   logic signed [SAMPLE_W-1:0]  out_ff;

   // Combinational helpers.
   logic [AW:0]                 wpos_inc;
   logic [PERIOD_W-1:0]         time_inc;
   logic [PERIOD_W-1:0]         time_next;
   logic [PERIOD_W:0]           rem_dbl;
   logic [PERIOD_W:0]           rem_sub;
   logic                        div_fit;
   logic [15:0]                 x_frac;
   logic [MAG_W-1:0]            x_pos;
   logic [MAG_W:0]              mag_raw;
   logic [15:0]                 m_val;
   logic [MAG_W-1:0]            c256;
   logic signed [DLW-1:0]       dly_raw;
   logic signed [DLW-1:0]       dly_clamp;
   logic [AW:0]                 tap_base;
   logic [AW:0]                 ip_sum;
   logic [AW-1:0]               rd_addr;
   logic [8:0]                  inv_f;
   logic signed [25:0]          acc_sum;
   logic signed [17:0]          mix_add;
   logic signed [SAMPLE_W-1:0]  sat_val;
   logic signed [17:0]          mul_a;
   logic signed [17:0]          mul_b;
   logic                        mul_en;
   logic                        mem_we;

   assign status.enable    = enable_ff;
   assign status.wpos_last = (wpos_ff == AW'(DELAY_DEPTH - 1));
   assign rsp_sample_out   = out_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         depth_ff  <= '0;
         period_ff <= 21'd50000;
         center_ff <= 9'd250;
         amp_ff    <= 8'd240;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE: enable_ff <= csr_wr_data[0];
            CSR_DEPTH:  depth_ff  <= csr_wr_data[DEPTH_W-1:0];
            CSR_PERIOD: period_ff <= csr_wr_data[PERIOD_W-1:0];
            CSR_CENTER: center_ff <= csr_wr_data[CENTER_W-1:0];
            CSR_AMP:    amp_ff    <= csr_wr_data[AMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Write position and LFO time advance, wrapping at the store depth and
   // at the period.
   assign wpos_inc  = {1'b0, wpos_ff} + 1'b1;
   assign time_inc  = lfo_time_ff + 1'b1;
   assign time_next = (time_inc >= period_ff) ? '0 : time_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff     <= '0;
         lfo_time_ff <= '0;
      end else begin
         if (cmd.op == OP_CLEAR || cmd.op == OP_STORE) begin
            wpos_ff <= (wpos_inc == DEPTH_X) ? '0 : wpos_inc[AW-1:0];
         end
         if (cmd.op == OP_STORE) begin
            lfo_time_ff <= time_next;
         end
      end
   end

   // Delay memory: one write port, one registered read port.
   assign mem_we  = (cmd.op == OP_CLEAR) || (cmd.op == OP_STORE);
   assign rd_addr = (cmd.op == OP_RDP) ? ip_ff : inx_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         delay_mem[wpos_ff] <= (cmd.op == OP_CLEAR) ? '0 : sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_RDP || cmd.op == OP_RDN) begin
         rd_ff <= delay_mem[rd_addr];
      end
   end

   // Restoring divider step for the phase; a zero period gives phase zero.
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_sub = rem_dbl - {1'b0, period_ff};
   assign div_fit = (period_ff != '0) && (rem_dbl >= {1'b0, period_ff});

   // Quarter-wave position, mirrored in the second and fourth quarters.
   assign x_frac = {quo_ff[QB-1:0], {(16 - QB){1'b0}}};
   assign x_pos  = quo_ff[QB] ? (SINE_ONE - {1'b0, x_frac}) : {1'b0, x_frac};

   // Polynomial result capped at one.
   assign mag_raw = prod_ff[33:16];

   // Q8 delay, clamped so both taps stay inside the store.
   assign m_val   = prod_ff[23:8];
   assign c256    = {center_ff, 8'd0};
   assign dly_raw = neg_ff ? ($signed(DLW'(c256)) - $signed(DLW'(m_val)))
                           : ($signed(DLW'(c256)) + $signed(DLW'(m_val)));
   always_comb begin
      if (dly_raw < DLY_MIN) begin
         dly_clamp = DLY_MIN;
      end else if (dly_raw > DLY_MAX) begin
         dly_clamp = DLY_MAX;
      end else begin
         dly_clamp = dly_raw;
      end
   end

   // Tap addresses behind the advanced write position, modulo the depth.
   assign tap_base = {1'b0, wpos_ff} + DEPTH_X - {1'b0, n_ff};
   assign ip_sum   = tap_base - 1'b1;

   // Interpolation and mix arithmetic.
   assign inv_f   = 9'd256 - {1'b0, f_ff};
   assign acc_sum = {acc_ff[24], acc_ff} + {prod_ff[24], prod_ff[24:0]};
   assign mix_add = $signed({{2{sample_ff[SAMPLE_W-1]}}, sample_ff})
                  + $signed({prod_ff[28], prod_ff[28:12]});
   always_comb begin
      if (mix_add > 18'sd32767) begin
         sat_val = 16'sh7FFF;
      end else if (mix_add < -18'sd32768) begin
         sat_val = 16'sh8000;
      end else begin
         sat_val = mix_add[SAMPLE_W-1:0];
      end
   end

   // Shared multiplier operand selection.
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (cmd.op)
         OP_SQ: begin
            mul_a = $signed({1'b0, x_ff});
            mul_b = $signed({1'b0, x_ff});
         end
         OP_PMUL: begin
            mul_a = $signed({1'b0, x2_ff});
            mul_b = $signed({1'b0, p_ff});
         end
         OP_XMUL: begin
            mul_a = $signed({1'b0, x_ff});
            mul_b = $signed({1'b0, p_ff});
         end
         OP_AMP: begin
            mul_a = $signed({10'd0, amp_ff});
            mul_b = $signed({1'b0, p_ff});
         end
         OP_RDN: begin
            mul_a = $signed({{2{rd_ff[SAMPLE_W-1]}}, rd_ff});
            mul_b = $signed({9'd0, inv_f});
         end
         OP_INTA: begin
            mul_a = $signed({{2{rd_ff[SAMPLE_W-1]}}, rd_ff});
            mul_b = $signed({10'd0, f_ff});
         end
         OP_MIX: begin
            mul_a = $signed({{2{delayed_ff[SAMPLE_W-1]}}, delayed_ff});
            mul_b = $signed({5'd0, depth_ff});
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // Per-step working registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_TAKE: begin
            sample_ff <= req_sample_in;
         end
         OP_STORE: begin
            rem_ff <= time_next;
            quo_ff <= '0;
         end
         OP_DIV: begin
            rem_ff <= div_fit ? rem_sub[PERIOD_W-1:0] : rem_dbl[PERIOD_W-1:0];
            quo_ff <= {quo_ff[SINE_TABLE_BITS-2:0], div_fit};
         end
         OP_XPOS: begin
            x_ff   <= x_pos;
            neg_ff <= quo_ff[SINE_TABLE_BITS-1];
         end
         OP_SQ: begin
            p_ff <= POLY_SEED;
         end
         OP_X2: begin
            x2_ff <= prod_ff[32:16];
         end
         OP_PSUB: begin
            p_ff <= poly_coef(cmd.idx) - prod_ff[32:16];
         end
         OP_MAG: begin
            p_ff <= (mag_raw > {1'b0, SINE_ONE}) ? SINE_ONE : mag_raw[MAG_W-1:0];
         end
         OP_DELAY: begin
            n_ff <= dly_clamp[AW+7:8];
            f_ff <= dly_clamp[7:0];
         end
         OP_ADDR: begin
            inx_ff <= (tap_base >= DEPTH_X) ? AW'(tap_base - DEPTH_X) : tap_base[AW-1:0];
            ip_ff  <= (ip_sum >= DEPTH_X) ? AW'(ip_sum - DEPTH_X) : ip_sum[AW-1:0];
         end
         OP_INTA: begin
            acc_ff <= prod_ff[24:0];
         end
         OP_INTB: begin
            delayed_ff <= acc_sum[23:8];
         end
         OP_SAT: begin
            out_ff <= sat_val;
         end
         OP_PASS: begin
            out_ff <= sample_ff;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ hdl/lfofl_checker.sv @@
// ----------------------------------------------------------------------------
// lfofl_checker
// Port-level checks for the flanger, bound to the top level.
// ----------------------------------------------------------------------------
`include "lfo_flanger_defines.svh"

module lfofl_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [lfofl_pkg::SAMPLE_W-1:0] rsp_sample_out
);

   // The memory clear holds off input items right after reset.
   `LFOFL_CHECK_ALWAYS(a_clear_stalls, reset |=> req_stall, "input taken during clear")

   // Only one item is worked on at a time.
   `LFOFL_CHECK(a_one_item, (req_valid && !req_stall) |=> req_stall, "item accepted while busy")

   // A new result appears only from a busy sequencer.
   `LFOFL_CHECK(a_rsp_from_work, $rose(rsp_valid) |-> $past(req_stall), "result without work")

   // A stalled result holds.
   `LFOFL_CHECK(a_rsp_hold,
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sample_out)),
      "stalled result changed")

endmodule

bind lfo_flanger lfofl_checker u_lfofl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out)
);
